[design/tksid_pkg.sv]
package tksid_pkg;

   localparam int TOP_ENTRIES_DEF = 16;
   localparam int MAX_DIM_DEF     = 16;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_OFFER  = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [2:0] ST_LOADED   = 3'd0;
   localparam logic [2:0] ST_INSERTED = 3'd1;
   localparam logic [2:0] ST_DUP      = 3'd2;
   localparam logic [2:0] ST_BELOW    = 3'd3;
   localparam logic [2:0] ST_READ     = 3'd4;

   localparam logic [4:0] DIM_RESET = 5'd16;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RANK_RD,
      S_RANK_WT,
      S_SCORE_WT,
      S_CMP,
      S_DECIDE,
      S_SLOT_WT,
      S_WSCORE,
      S_WWGT,
      S_SH_RD,
      S_SH_WT,
      S_RWGT_WT,
      S_DONE
   } state_type;

   // Ten times a Q8.8 weight, truncated toward zero to an integer.
   function automatic logic signed [11:0] tenfold_trunc(input logic signed [15:0] w);
      logic signed [19:0] prod;
      logic signed [19:0] adj;
      prod = 20'(w) * 20'sd10;
      adj  = (prod < 0) ? (prod + 20'sd255) : prod;
      return 12'(adj >>> 8);
   endfunction

endpackage

[design/tksid_ram.sv]
module tksid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[design/tksid_csr.sv]
module tksid_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [4:0]  dim_in_use
);

   logic [4:0] dim_ff;
   logic [4:0] dim_in;
   logic       hit;

   assign hit = (csr_paddr == 2'd0);

   always_comb begin
      dim_in = dim_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         dim_in = csr_pwdata[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= tksid_pkg::DIM_RESET;
      end else begin
         dim_ff <= dim_in;
      end
   end

   assign csr_prdata = hit ? {27'd0, dim_ff} : 32'd0;
   assign csr_pready = 1'b1;
   assign dim_in_use = dim_ff;

endmodule

[design/top_k_sorted_insert_dedup.sv]
// Sequence: a load writes the pending vector; a read fetches its rank's slot, score and one
// weight. An offer reads slot and score per rank, compares weights on an equal score and,
// unless a duplicate or below a full table, writes score and all MAX_DIM weights and shifts
// lower ranks down. One item at a time on synchronous RAMs; a stalled result holds the block.
// Reset: synchronous, active high; clears the entry count and the pending vector and sets
// dim_in_use to 16. The RAMs are not cleared, since no read reaches an unwritten entry.
module top_k_sorted_insert_dedup #(
   parameter int TOP_ENTRIES = tksid_pkg::TOP_ENTRIES_DEF,
   parameter int MAX_DIM     = tksid_pkg::MAX_DIM_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_score,
   input  logic signed [15:0] req_weight,
   input  logic [3:0]         req_element,
   input  logic [3:0]         req_rank,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [3:0]         rsp_position,
   output logic [4:0]         rsp_entry_count,
   output logic signed [31:0] rsp_read_score,
   output logic signed [15:0] rsp_read_weight,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [1:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int RW  = $clog2(TOP_ENTRIES);
   localparam int CW  = $clog2(TOP_ENTRIES + 1);
   localparam int EW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int ECW = $clog2(MAX_DIM + 1);
   localparam int WD  = TOP_ENTRIES * MAX_DIM;
   localparam int AW  = $clog2(WD);

   // Configuration register.
   logic [4:0]     dim_cfg;
   logic [ECW-1:0] dim_eff;

   tksid_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .dim_in_use  (dim_cfg)
   );

   // A dimension above MAX_DIM behaves as MAX_DIM.
   assign dim_eff = (32'(dim_cfg) > MAX_DIM) ? ECW'(MAX_DIM) : ECW'(dim_cfg);

   // Memories: rank list (slot per rank), slot scores and slot weight vectors.
   logic          rank_we;
   logic [RW-1:0] rank_waddr, rank_wdata, rank_raddr, rank_q;
   logic          score_we;
   logic [RW-1:0] score_waddr, score_raddr;
   logic [31:0]   score_wdata, score_q;
   logic          wgt_we;
   logic [AW-1:0] wgt_waddr, wgt_raddr;
   logic [15:0]   wgt_wdata, wgt_q;

   tksid_ram #(.WIDTH(RW), .DEPTH(TOP_ENTRIES)) u_rank (
      .clock (clock), .we (rank_we), .waddr (rank_waddr), .wdata (rank_wdata),
      .raddr (rank_raddr), .rdata (rank_q)
   );

   tksid_ram #(.WIDTH(32), .DEPTH(TOP_ENTRIES)) u_score (
      .clock (clock), .we (score_we), .waddr (score_waddr), .wdata (score_wdata),
      .raddr (score_raddr), .rdata (score_q)
   );

   tksid_ram #(.WIDTH(16), .DEPTH(WD)) u_wgt (
      .clock (clock), .we (wgt_we), .waddr (wgt_waddr), .wdata (wgt_wdata),
      .raddr (wgt_raddr), .rdata (wgt_q)
   );

   function automatic logic [AW-1:0] wgt_addr(input logic [RW-1:0] s, input logic [ECW-1:0] e);
      return AW'(s * MAX_DIM + e);
   endfunction

   // Sequencer state and working registers.
   tksid_pkg::state_type state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic signed [31:0] sc_ff, sc_in;
   logic [3:0]         el_ff, el_in;
   logic [CW-1:0]      r_ff, r_in;
   logic [CW-1:0]      p_ff, p_in;
   logic [ECW-1:0]     e_ff, e_in;
   logic [RW-1:0]      slot_ff, slot_in;
   logic [RW-1:0]      nslot_ff, nslot_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [2:0]         stat_ff, stat_in;
   logic [31:0]        rscore_ff, rscore_in;
   logic [15:0]        rweight_ff, rweight_in;
   logic [15:0]        pend_ff [MAX_DIM];
   logic [15:0]        pend_in [MAX_DIM];

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [3:0]  rsp_position_ff, rsp_position_in;
   logic [4:0]  rsp_count_ff, rsp_count_in;
   logic [31:0] rsp_rscore_ff, rsp_rscore_in;
   logic [15:0] rsp_rweight_ff, rsp_rweight_in;

   // Shared decisions.
   logic          accept, out_free;
   logic          score_gt, score_eq, wmatch, last_rank, last_elem, full;
   logic          rank_ok, el_ok, req_el_ok;
   logic [CW-1:0] r_next, r_dec;
   logic [EW-1:0] e_idx, req_el_idx, el_idx;
   logic [8:0]    p_wide, count_wide;

   assign accept     = req_valid && (state_ff == tksid_pkg::S_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign score_gt   = $signed(score_q) > sc_ff;
   assign score_eq   = $signed(score_q) == sc_ff;
   assign e_idx      = e_ff[EW-1:0];
   assign wmatch     = tksid_pkg::tenfold_trunc(wgt_q) ==
                       tksid_pkg::tenfold_trunc(pend_ff[e_idx]);
   assign r_next     = r_ff + 1'b1;
   assign r_dec      = r_ff - 1'b1;
   assign last_rank  = (r_next == count_ff);
   assign last_elem  = (e_ff + 1'b1) == dim_eff;
   assign full       = (count_ff == CW'(TOP_ENTRIES));
   assign rank_ok    = 9'(req_rank) < 9'(count_ff);
   assign req_el_ok  = 32'(req_element) < MAX_DIM;
   assign el_ok      = 32'(el_ff) < MAX_DIM;
   assign req_el_idx = EW'(req_element);
   assign el_idx     = EW'(el_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tksid_pkg::S_IDLE: begin
            if (accept) begin
               case (req_op)
                  tksid_pkg::OP_LOAD:  state_in = tksid_pkg::S_DONE;
                  tksid_pkg::OP_OFFER: state_in = (count_ff == '0) ? tksid_pkg::S_DECIDE
                                                                   : tksid_pkg::S_RANK_RD;
                  tksid_pkg::OP_READ:  state_in = rank_ok ? tksid_pkg::S_RANK_RD
                                                          : tksid_pkg::S_DONE;
                  default:             state_in = tksid_pkg::S_IDLE;
               endcase
            end
         end
         tksid_pkg::S_RANK_RD: state_in = tksid_pkg::S_RANK_WT;
         tksid_pkg::S_RANK_WT: state_in = tksid_pkg::S_SCORE_WT;
         tksid_pkg::S_SCORE_WT: begin
            if (op_ff == tksid_pkg::OP_READ) begin
               state_in = el_ok ? tksid_pkg::S_RWGT_WT : tksid_pkg::S_DONE;
            end else if (score_gt) begin
               state_in = last_rank ? tksid_pkg::S_DECIDE : tksid_pkg::S_RANK_RD;
            end else if (score_eq) begin
               state_in = (dim_eff == '0) ? tksid_pkg::S_DONE : tksid_pkg::S_CMP;
            end else begin
               state_in = tksid_pkg::S_DECIDE;
            end
         end
         tksid_pkg::S_CMP: begin
            if (!wmatch) begin
               state_in = last_rank ? tksid_pkg::S_DECIDE : tksid_pkg::S_RANK_RD;
            end else if (last_elem) begin
               state_in = tksid_pkg::S_DONE;
            end
         end
         tksid_pkg::S_DECIDE: begin
            if (full && p_ff == CW'(TOP_ENTRIES)) begin
               state_in = tksid_pkg::S_DONE;
            end else if (full) begin
               state_in = tksid_pkg::S_SLOT_WT;
            end else begin
               state_in = tksid_pkg::S_WSCORE;
            end
         end
         tksid_pkg::S_SLOT_WT: state_in = tksid_pkg::S_WSCORE;
         tksid_pkg::S_WSCORE:  state_in = tksid_pkg::S_WWGT;
         tksid_pkg::S_WWGT: begin
            if (e_ff == ECW'(MAX_DIM - 1)) begin
               state_in = tksid_pkg::S_SH_RD;
            end
         end
         tksid_pkg::S_SH_RD: state_in = (r_ff > p_ff) ? tksid_pkg::S_SH_WT : tksid_pkg::S_DONE;
         tksid_pkg::S_SH_WT: state_in = tksid_pkg::S_SH_RD;
         tksid_pkg::S_RWGT_WT: state_in = tksid_pkg::S_DONE;
         tksid_pkg::S_DONE: begin
            if (out_free) begin
               state_in = tksid_pkg::S_IDLE;
            end
         end
         default: state_in = tksid_pkg::S_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      op_in      = op_ff;
      sc_in      = sc_ff;
      el_in      = el_ff;
      r_in       = r_ff;
      p_in       = p_ff;
      e_in       = e_ff;
      slot_in    = slot_ff;
      nslot_in   = nslot_ff;
      count_in   = count_ff;
      stat_in    = stat_ff;
      rscore_in  = rscore_ff;
      rweight_in = rweight_ff;
      pend_in    = pend_ff;

      rank_we     = 1'b0;
      rank_waddr  = r_ff[RW-1:0];
      rank_wdata  = rank_q;
      rank_raddr  = r_ff[RW-1:0];
      score_we    = 1'b0;
      score_waddr = nslot_ff;
      score_wdata = sc_ff;
      score_raddr = rank_q;
      wgt_we      = 1'b0;
      wgt_waddr   = wgt_addr(nslot_ff, e_ff);
      wgt_wdata   = '0;
      wgt_raddr   = wgt_addr(slot_ff, e_ff + 1'b1);

      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_status_in   = rsp_status_ff;
      rsp_position_in = rsp_position_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_rscore_in   = rsp_rscore_ff;
      rsp_rweight_in  = rsp_rweight_ff;

      unique case (state_ff)
         tksid_pkg::S_IDLE: begin
            if (accept) begin
               op_in      = req_op;
               sc_in      = req_score;
               el_in      = req_element;
               r_in       = '0;
               p_in       = '0;
               rscore_in  = '0;
               rweight_in = '0;
               case (req_op)
                  tksid_pkg::OP_LOAD: begin
                     stat_in = tksid_pkg::ST_LOADED;
                     if (req_el_ok) begin
                        pend_in[req_el_idx] = req_weight;
                     end
                  end
                  tksid_pkg::OP_READ: begin
                     stat_in = tksid_pkg::ST_READ;
                     r_in    = CW'(req_rank);
                  end
                  default: ;
               endcase
            end
         end
         tksid_pkg::S_RANK_RD: ;
         tksid_pkg::S_RANK_WT: begin
            slot_in = rank_q;
         end
         tksid_pkg::S_SCORE_WT: begin
            if (op_ff == tksid_pkg::OP_READ) begin
               rscore_in = score_q;
               wgt_raddr = wgt_addr(slot_ff, ECW'(el_idx));
            end else if (score_gt) begin
               r_in = r_next;
               p_in = r_next;
            end else if (score_eq) begin
               e_in      = '0;
               wgt_raddr = wgt_addr(slot_ff, '0);
               stat_in   = tksid_pkg::ST_DUP;
            end else begin
               p_in = r_ff;
            end
         end
         tksid_pkg::S_CMP: begin
            if (!wmatch) begin
               r_in = r_next;
               p_in = r_next;
            end else begin
               e_in = e_ff + 1'b1;
            end
         end
         tksid_pkg::S_DECIDE: begin
            rank_raddr = RW'(TOP_ENTRIES - 1);
            if (full && p_ff == CW'(TOP_ENTRIES)) begin
               stat_in = tksid_pkg::ST_BELOW;
            end else if (full) begin
               r_in = CW'(TOP_ENTRIES - 1);
            end else begin
               nslot_in = count_ff[RW-1:0];
               r_in     = count_ff;
               count_in = count_ff + 1'b1;
            end
         end
         tksid_pkg::S_SLOT_WT: begin
            nslot_in = rank_q;
         end
         tksid_pkg::S_WSCORE: begin
            score_we = 1'b1;
            e_in     = '0;
         end
         tksid_pkg::S_WWGT: begin
            wgt_we    = 1'b1;
            wgt_wdata = (e_ff < dim_eff) ? pend_ff[e_idx] : 16'd0;
            e_in      = e_ff + 1'b1;
         end
         tksid_pkg::S_SH_RD: begin
            rank_raddr = r_dec[RW-1:0];
            if (!(r_ff > p_ff)) begin
               // Shifting is done: drop the new slot into its rank.
               rank_we    = 1'b1;
               rank_waddr = p_ff[RW-1:0];
               rank_wdata = nslot_ff;
               stat_in    = tksid_pkg::ST_INSERTED;
            end
         end
         tksid_pkg::S_SH_WT: begin
            rank_we = 1'b1;
            r_in    = r_dec;
         end
         tksid_pkg::S_RWGT_WT: begin
            rweight_in = wgt_q;
         end
         tksid_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = stat_ff;
               rsp_position_in = (stat_ff == tksid_pkg::ST_INSERTED) ? p_wide[3:0] : 4'd0;
               rsp_count_in    = count_wide[4:0];
               rsp_rscore_in   = rscore_ff;
               rsp_rweight_in  = rweight_ff;
            end
         end
         default: ;
      endcase
   end

   assign p_wide     = 9'(p_ff);
   assign count_wide = 9'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tksid_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_DIM; i++) begin
            pend_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
      op_ff           <= op_in;
      sc_ff           <= sc_in;
      el_ff           <= el_in;
      r_ff            <= r_in;
      p_ff            <= p_in;
      e_ff            <= e_in;
      slot_ff         <= slot_in;
      nslot_ff        <= nslot_in;
      stat_ff         <= stat_in;
      rscore_ff       <= rscore_in;
      rweight_ff      <= rweight_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_position_ff <= rsp_position_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_rscore_ff   <= rsp_rscore_in;
      rsp_rweight_ff  <= rsp_rweight_in;
   end

   assign req_stall       = (state_ff != tksid_pkg::S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_read_score  = rsp_rscore_ff;
   assign rsp_read_weight = rsp_rweight_ff;

endmodule

[tb/sv/tb_top.sv]
// Self-checking bench for the top-k sorted insertion buffer with duplicate rejection.
// A behavioral rank list in the bench predicts the result of every accepted item but the unused op.
// Results are queued in order and compared field by field as the block returns them.
module tb_top;

   localparam int N_ENT = 16;
   localparam int N_DIM = 16;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [2:0]         status;
      logic [3:0]         position;
      logic [4:0]         entry_count;
      logic signed [31:0] read_score;
      logic signed [15:0] read_weight;
   } rsp_item_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_op = tksid_pkg::OP_LOAD;
   logic signed [31:0] req_score = '0;
   logic signed [15:0] req_weight = '0;
   logic [3:0]         req_element = '0;
   logic [3:0]         req_rank = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_status;
   logic [3:0]         rsp_position;
   logic [4:0]         rsp_entry_count;
   logic signed [31:0] rsp_read_score;
   logic signed [15:0] rsp_read_weight;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [1:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   top_k_sorted_insert_dedup i_dut (.*);

   always #4 clock = ~clock;

   // Predicted state of the rank list.
   logic [3:0]         rank_slot [N_ENT];
   logic signed [31:0] slot_scores [N_ENT];
   logic signed [15:0] slot_wts [N_ENT][N_DIM];
   logic signed [15:0] pend_wts [N_DIM];
   int unsigned        live_count;
   logic [4:0]         dim_cfg;

   rsp_item_type expected_rsps[$];
   int  error_count = 0;
   int  cycle_count = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;

   // Integer part of ten times a Q8.8 weight, rounded toward zero.
   function automatic int tenfold(input logic signed [15:0] w);
      int p;
      p = int'(w) * 10;
      return (p < 0) ? -((-p) / 256) : p / 256;
   endfunction

   function automatic rsp_item_type predict_item(input logic [1:0] op,
         input logic signed [31:0] sc, input logic signed [15:0] w, input logic [3:0] el,
         input logic [3:0] rk);
      rsp_item_type r;
      int unsigned dim, p, cnt;
      logic [3:0] slot;
      bit dup, same;
      r = '0;
      dim = (dim_cfg > N_DIM) ? N_DIM : dim_cfg;
      if (op == tksid_pkg::OP_LOAD) begin
         pend_wts[el] = w;
         r.status = tksid_pkg::ST_LOADED;
      end else if (op == tksid_pkg::OP_OFFER) begin
         dup = 0;
         for (int i = 0; i < live_count; i++) begin
            if (slot_scores[rank_slot[i]] == sc) begin
               same = 1;
               for (int e = 0; e < dim; e++)
                  if (tenfold(slot_wts[rank_slot[i]][e]) != tenfold(pend_wts[e])) same = 0;
               if (same) dup = 1;
            end
         end
         if (dup) begin
            r.status = tksid_pkg::ST_DUP;
         end else begin
            p = 0;
            while (p < live_count && slot_scores[rank_slot[p]] >= sc) p++;
            if (live_count >= N_ENT && p >= N_ENT) begin
               r.status = tksid_pkg::ST_BELOW;
            end else begin
               // A full table recycles the slot of its lowest entry.
               if (live_count >= N_ENT) begin
                  slot = rank_slot[N_ENT-1];
                  cnt = N_ENT - 1;
               end else begin
                  slot = live_count[3:0];
                  cnt = live_count;
                  live_count++;
               end
               slot_scores[slot] = sc;
               for (int e = 0; e < N_DIM; e++)
                  slot_wts[slot][e] = (e < dim) ? pend_wts[e] : 16'sd0;
               for (int i = cnt; i > p; i--) rank_slot[i] = rank_slot[i-1];
               rank_slot[p] = slot;
               r.status = tksid_pkg::ST_INSERTED;
               r.position = p[3:0];
            end
         end
      end else begin
         r.status = tksid_pkg::ST_READ;
         if (rk < live_count) begin
            r.read_score = slot_scores[rank_slot[rk]];
            r.read_weight = slot_wts[rank_slot[rk]][el];
         end
      end
      r.entry_count = live_count[4:0];
      return r;
   endfunction

   // Send one item; the prediction is made when the block accepts it.
   task automatic send_item(input logic [1:0] op, input logic signed [31:0] sc,
         input logic signed [15:0] w, input logic [3:0] el, input logic [3:0] rk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid = 1'b1;
      req_op = op;
      req_score = sc;
      req_weight = w;
      req_element = el;
      req_rank = rk;
      do @(posedge clock); while (req_stall);
      if (op != tksid_pkg::OP_UNUSED) begin
         expected_rsps.push_back(predict_item(op, sc, w, el, rk));
      end
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Wait until every expected result is back, then let the block settle.
   task automatic drain;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_dim(input logic [4:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= 2'd0;
      csr_pwdata <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      dim_cfg = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Load a full pending vector with random values.
   task automatic load_vector;
      for (int e = 0; e < N_DIM; e++)
         send_item(tksid_pkg::OP_LOAD, 32'($urandom), 16'($urandom), e[3:0], 4'($urandom));
   endtask

   // Directed: weight extremes, ties, duplicates, rounding toward zero, reads past the end.
   task automatic test_directed;
      send_item(tksid_pkg::OP_READ, 0, 0, 0, 0);
      send_item(tksid_pkg::OP_LOAD, 0, 16'sh7fff, 4'd0, 0);
      send_item(tksid_pkg::OP_LOAD, 0, -16'sh8000, 4'd15, 0);
      send_item(tksid_pkg::OP_OFFER, 32'sh7fffffff, 0, 0, 0);
      send_item(tksid_pkg::OP_OFFER, 32'sh7fffffff, 0, 0, 0);
      // Small weights truncate to zero on both sides of zero, so these are duplicates.
      send_item(tksid_pkg::OP_LOAD, 0, 16'sd25, 4'd0, 0);
      send_item(tksid_pkg::OP_LOAD, 0, -16'sd25, 4'd15, 0);
      send_item(tksid_pkg::OP_OFFER, 32'sh80000000, 0, 0, 0);
      send_item(tksid_pkg::OP_LOAD, 0, 16'sd0, 4'd0, 0);
      send_item(tksid_pkg::OP_LOAD, 0, 16'sd0, 4'd15, 0);
      send_item(tksid_pkg::OP_OFFER, 32'sh80000000, 0, 0, 0);
      send_item(tksid_pkg::OP_LOAD, 0, 16'sd26, 4'd0, 0);
      send_item(tksid_pkg::OP_OFFER, 32'sh80000000, 0, 0, 0);
      send_item(tksid_pkg::OP_OFFER, 32'sh7fffffff, 0, 0, 0);
      send_item(tksid_pkg::OP_READ, 0, 0, 4'd0, 4'd1);
      send_item(tksid_pkg::OP_READ, 0, 0, 4'd15, 4'd3);
      send_item(tksid_pkg::OP_READ, 0, 0, 4'd0, 4'd15);
      send_item(tksid_pkg::OP_UNUSED, 0, 0, 0, 0);
      send_item(tksid_pkg::OP_READ, 0, 0, 4'd15, 4'd0);
   endtask

   // Random loads, offers, reads and unused ops; most scores fall in a narrow range so ties,
   // duplicates and full-table rejections are common; half the loads use small weights to provoke duplicates.
   task automatic test_random(input int n);
      int k;
      logic [1:0] op;
      logic signed [31:0] sc;
      logic signed [15:0] w;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         op = (k < 45) ? tksid_pkg::OP_LOAD : (k < 75) ? tksid_pkg::OP_OFFER :
              (k < 97) ? tksid_pkg::OP_READ : tksid_pkg::OP_UNUSED;
         sc = ($urandom_range(3) == 0) ? 32'($urandom) : 32'($urandom_range(12)) - 6;
         w = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(60)) - 30;
         send_item(op, sc, w, 4'($urandom), 4'($urandom));
      end
   endtask

   // Alternate a load of one random element with an offer of a random score to fill the table.
   task automatic test_fill_table;
      for (int i = 0; i < 20; i++) begin
         send_item(tksid_pkg::OP_LOAD, 0, 16'($urandom), 4'($urandom_range(N_DIM-1)), 0);
         send_item(tksid_pkg::OP_OFFER, 32'($urandom_range(40)) - 20, 0, 0, 0);
      end
   endtask

   // Compare every result with the oldest prediction.
   always @(posedge clock) begin
      rsp_item_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("result with no item pending");
            error_count++;
         end else begin
            exp_r = expected_rsps.pop_front();
            if (rsp_status !== exp_r.status) begin
               $error("status exp %0d got %0d", exp_r.status, rsp_status); error_count++;
            end
            if (rsp_position !== exp_r.position) begin
               $error("position exp %0d got %0d", exp_r.position, rsp_position); error_count++;
            end
            if (rsp_entry_count !== exp_r.entry_count) begin
               $error("entry_count exp %0d got %0d", exp_r.entry_count, rsp_entry_count);
               error_count++;
            end
            if (rsp_read_score !== exp_r.read_score) begin
               $error("read_score exp %0d got %0d", exp_r.read_score, rsp_read_score);
               error_count++;
            end
            if (rsp_read_weight !== exp_r.read_weight) begin
               $error("read_weight exp %0d got %0d", exp_r.read_weight, rsp_read_weight);
               error_count++;
            end
         end
      end
   end

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      live_count = 0;
      dim_cfg = tksid_pkg::DIM_RESET;
      for (int e = 0; e < N_DIM; e++) pend_wts[e] = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 15;
      recv_stall_pct = 59;
      test_directed();
      drain();
      write_dim(5'd1);
      test_fill_table();
      test_random(250);
      drain();
      write_dim(5'd0);
      test_random(100);
      drain();
      send_idle_pct = 59;
      recv_stall_pct = 15;
      write_dim(5'd31);
      load_vector();
      test_random(200);
      drain();
      write_dim(5'd4);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random(200);
      drain();
      write_dim(5'd16);
      test_random(50);
      drain();
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
